FILE: rtl/assert_macros.svh
// Assertion helpers shared by the cache controller modules.
// Every check is sampled on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when pre holds, post must hold in the same cycle.
`define DMC_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication: when pre holds, post must hold in the next cycle.
`define DMC_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/dmc_pkg.sv
package dmc_pkg;

   // Response status codes
   localparam logic [2:0] RSP_HIT      = 3'd0;
   localparam logic [2:0] RSP_MISS     = 3'd1;
   localparam logic [2:0] RSP_WAIT     = 3'd2;
   localparam logic [2:0] RSP_FILL_OK  = 3'd3;
   localparam logic [2:0] RSP_FILL_IGN = 3'd4;

   // Line state codes
   localparam logic [1:0] LINE_INVALID = 2'd0;
   localparam logic [1:0] LINE_VALID   = 2'd1;
   localparam logic [1:0] LINE_PENDING = 2'd2;

   // Request function codes
   localparam logic FUNC_ACCESS = 1'b0;
   localparam logic FUNC_FILL   = 1'b1;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned WORD_BYTES = 4;
   localparam int unsigned ROW_WORDS  = 4;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned REQ_DATA_W = 144;
   localparam int unsigned RSP_DATA_W = 72;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef logic [WORD_W*ROW_WORDS-1:0] row_type;

   // Lookup request from the input stage
   typedef struct packed {
      logic       vld;
      logic       func;
      logic [1:0] tag;
   } lookup_req_type;

   // Lookup outcome and counter values after the word
   typedef struct packed {
      logic [2:0]       status;
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] misses;
   } lookup_rsp_type;

endpackage

FILE: rtl/dmc_data_ram.sv
module dmc_data_ram #(
   parameter int unsigned AW = 2
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  dmc_pkg::row_type wr_row,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output dmc_pkg::row_type rd_row
);

   dmc_pkg::row_type mem [2**AW];
   dmc_pkg::row_type rd_row_ff;

   // Write a whole line; read one line, passing a same-cycle write through
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_row_ff <= wr_row;
         end else begin
            rd_row_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_row = rd_row_ff;

endmodule

FILE: rtl/dmc_lookup.sv
`include "assert_macros.svh"

module dmc_lookup #(
   parameter int unsigned IW = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dmc_pkg::lookup_req_type lk_req,
   input  logic [IW-1:0]           lk_idx,
   output dmc_pkg::lookup_rsp_type lk_rsp
);

   localparam int unsigned LINES = 2**IW;

   logic [1:0]                  tag_ff [LINES];
   logic [1:0]                  st_ff  [LINES];
   logic [dmc_pkg::CNT_W-1:0]   hits_ff;
   logic [dmc_pkg::CNT_W-1:0]   misses_ff;
   logic [dmc_pkg::CNT_W-1:0]   hits_in;
   logic [dmc_pkg::CNT_W-1:0]   misses_in;
   logic [1:0]                  cur_tag;
   logic [1:0]                  cur_st;
   logic                        match;
   logic [2:0]                  status;

   assign cur_tag = tag_ff[lk_idx];
   assign cur_st  = st_ff[lk_idx];
   assign match   = (cur_tag == lk_req.tag);

   // Classify the word against the addressed line
   always_comb begin
      if (lk_req.func == dmc_pkg::FUNC_ACCESS) begin
         if (match && (cur_st == dmc_pkg::LINE_VALID)) begin
            status = dmc_pkg::RSP_HIT;
         end else if (match && (cur_st == dmc_pkg::LINE_PENDING)) begin
            status = dmc_pkg::RSP_WAIT;
         end else begin
            status = dmc_pkg::RSP_MISS;
         end
      end else begin
         if (match && (cur_st == dmc_pkg::LINE_PENDING)) begin
            status = dmc_pkg::RSP_FILL_OK;
         end else begin
            status = dmc_pkg::RSP_FILL_IGN;
         end
      end
   end

   // Saturating counters after this word
   always_comb begin
      hits_in   = hits_ff;
      misses_in = misses_ff;
      if ((status == dmc_pkg::RSP_HIT) && (hits_ff != dmc_pkg::CNT_MAX)) begin
         hits_in = hits_ff + 1'b1;
      end
      if ((status == dmc_pkg::RSP_MISS) && (misses_ff != dmc_pkg::CNT_MAX)) begin
         misses_in = misses_ff + 1'b1;
      end
   end

   assign lk_rsp.status = status;
   assign lk_rsp.hits   = hits_in;
   assign lk_rsp.misses = misses_in;

   // Update line state and counters when the word advances
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            tag_ff[i] <= '0;
            st_ff[i]  <= dmc_pkg::LINE_INVALID;
         end
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (lk_req.vld) begin
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         if (status == dmc_pkg::RSP_MISS) begin
            st_ff[lk_idx]  <= dmc_pkg::LINE_PENDING;
            tag_ff[lk_idx] <= lk_req.tag;
         end else if (status == dmc_pkg::RSP_FILL_OK) begin
            st_ff[lk_idx] <= dmc_pkg::LINE_VALID;
         end
      end
   end

   `DMC_ASSERT_NEXT(a_miss_marks_pending, lk_req.vld && (status == dmc_pkg::RSP_MISS), st_ff[$past(lk_idx)] == dmc_pkg::LINE_PENDING, "miss did not leave line pending")
   `DMC_ASSERT_NEXT(a_miss_counts, lk_req.vld && (status == dmc_pkg::RSP_MISS), misses_ff != '0, "miss counter still zero after a miss")

endmodule

FILE: rtl/direct_mapped_cache_controller_top.sv
// Direct-mapped cache line controller.
// req_ channel: one word is an access (req_tuser = 0, byte address) or a
// block fill returning from memory (req_tuser = 1, block, tag, four words).
// rsp_ channel: one word per request: status in rsp_tuser, and the block to
// fetch on a miss, the addressed word on a hit and both saturating counters.
// Path: a request is taken into the input register and its result is held
// in the result register for rsp_. Throughput: one request per cycle unless
// rsp_tready stalls; the lookup, line-state update and counters sit in one pass
// between the two registers, and the line data RAM is read as the request is taken.
// Stalls: while rsp_tready is low the result holds; one more request may be
// taken into the input register, after that req_tready drops until the
// result drains.
// Reset clears all line tags and states to invalid and both counters at once,
// so requests are taken as soon as reset is released; line data is not
// cleared and is only used on a hit, after a fill has written it.
// BLOCK_BYTES and CACHE_BYTES must be powers of two; the block itself does not check this.
`include "assert_macros.svh"

module direct_mapped_cache_controller_top #(
   parameter int unsigned BLOCK_BYTES = 16,
   parameter int unsigned CACHE_BYTES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // address[7:0], fill_block[11:8], fill_tag[13:12], fill_word0[45:14],
   // fill_word1[77:46], fill_word2[109:78], fill_word3[141:110], zero[143:142]
   input  logic [dmc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // miss_block[3:0], hit_word[35:4], hits_seen[51:36], misses_seen[67:52],
   // zero[71:68]
   output logic [dmc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status[2:0]
   output logic [2:0]                       rsp_tuser
);

   localparam int unsigned BOFF     = $clog2(BLOCK_BYTES);
   localparam int unsigned WPB      = BLOCK_BYTES / dmc_pkg::WORD_BYTES;
   localparam int unsigned NLINES   = (CACHE_BYTES / BLOCK_BYTES) > 0 ?
                                      (CACHE_BYTES / BLOCK_BYTES) : 1;
   localparam int unsigned IDXW     = $clog2(NLINES);
   localparam int unsigned ACC_LINES = 256 / BLOCK_BYTES;
   localparam int unsigned REACH    = ACC_LINES > 16 ? ACC_LINES : 16;
   localparam int unsigned PHYS     = NLINES < REACH ? NLINES : REACH;
   localparam int unsigned IW       = PHYS > 1 ? $clog2(PHYS) : 1;
   localparam int unsigned IDX_MASK_I = NLINES >= 256 ? 255 : NLINES - 1;
   localparam logic [7:0] IDX_MASK  = IDX_MASK_I[7:0];
   localparam int unsigned OFF_MASK_I = WPB - 1;
   localparam logic [7:0] OFF_MASK  = OFF_MASK_I[7:0];
   localparam int unsigned WW       = dmc_pkg::WORD_W;

   // Request fields
   logic [7:0]       in_address;
   logic [3:0]       in_fill_block;
   logic [1:0]       in_fill_tag;
   dmc_pkg::row_type in_row;
   logic [7:0]       acc_blk;
   logic [7:0]       acc_shift;
   logic [7:0]       acc_idx8;
   logic [7:0]       fill_idx8;
   logic [7:0]       off8;
   logic [IW-1:0]    in_idx;
   logic [1:0]       in_tag;
   logic             req_acc;

   // Input stage
   logic             s_vld_ff;
   logic             s_func_ff;
   logic [1:0]       s_tag_ff;
   logic [IW-1:0]    s_idx_ff;
   logic [1:0]       s_off_ff;
   logic             s_off_hi_ff;
   logic [3:0]       s_blk_ff;
   dmc_pkg::row_type s_row_ff;
   logic             advance;

   // Result register
   logic                      o_vld_ff;
   logic [2:0]                o_status_ff;
   logic [3:0]                o_blk_ff;
   logic [WW-1:0]             o_word_ff;
   logic [dmc_pkg::CNT_W-1:0] o_hits_ff;
   logic [dmc_pkg::CNT_W-1:0] o_misses_ff;
   logic [3:0]                o_blk_in;
   logic [WW-1:0]             o_word_in;

   dmc_pkg::lookup_req_type lk_req;
   dmc_pkg::lookup_rsp_type lk_rsp;
   dmc_pkg::row_type        rd_row;
   logic                    fill_wr;

   // Split the request word
   assign in_address    = req_tdata[7:0];
   assign in_fill_block = req_tdata[11:8];
   assign in_fill_tag   = req_tdata[13:12];
   assign in_row        = req_tdata[141:14];

   assign acc_blk   = in_address >> BOFF;
   assign acc_shift = acc_blk >> IDXW;
   assign acc_idx8  = acc_blk & IDX_MASK;
   assign fill_idx8 = {4'b0000, in_fill_block} & IDX_MASK;
   assign off8      = (in_address >> 2) & OFF_MASK;
   assign in_idx    = (req_tuser == dmc_pkg::FUNC_FILL) ? fill_idx8[IW-1:0]
                                                        : acc_idx8[IW-1:0];
   assign in_tag    = (req_tuser == dmc_pkg::FUNC_FILL) ? in_fill_tag : acc_shift[1:0];

   // Handshake: the stage moves on when the result register is free or drains
   assign advance    = s_vld_ff && (!o_vld_ff || rsp_tready);
   assign req_tready = !s_vld_ff || advance;
   assign req_acc    = req_tvalid && req_tready;

   // Load the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s_func_ff   <= req_tuser;
         s_tag_ff    <= in_tag;
         s_idx_ff    <= in_idx;
         s_off_ff    <= off8[1:0];
         s_off_hi_ff <= (off8[7:2] != 6'd0);
         s_blk_ff    <= acc_blk[3:0];
         s_row_ff    <= in_row;
      end
   end

   assign lk_req.vld  = advance;
   assign lk_req.func = s_func_ff;
   assign lk_req.tag  = s_tag_ff;

   dmc_lookup #(
      .IW (IW)
   ) u_lookup (
      .clock  (clock),
      .reset  (reset),
      .lk_req (lk_req),
      .lk_idx (s_idx_ff),
      .lk_rsp (lk_rsp)
   );

   assign fill_wr = advance && (lk_rsp.status == dmc_pkg::RSP_FILL_OK);

   dmc_data_ram #(
      .AW (IW)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (fill_wr),
      .wr_addr (s_idx_ff),
      .wr_row  (s_row_ff),
      .rd_en   (req_acc),
      .rd_addr (in_idx),
      .rd_row  (rd_row)
   );

   // Form the result fields
   always_comb begin
      o_blk_in  = '0;
      o_word_in = '0;
      if (lk_rsp.status == dmc_pkg::RSP_MISS) begin
         o_blk_in = s_blk_ff;
      end
      if ((lk_rsp.status == dmc_pkg::RSP_HIT) && !s_off_hi_ff) begin
         o_word_in = rd_row[s_off_ff*WW +: WW];
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (advance) begin
         o_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         o_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_status_ff <= lk_rsp.status;
         o_blk_ff    <= o_blk_in;
         o_word_ff   <= o_word_in;
         o_hits_ff   <= lk_rsp.hits;
         o_misses_ff <= lk_rsp.misses;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tuser  = o_status_ff;
   assign rsp_tdata  = {4'b0000, o_misses_ff, o_hits_ff, o_word_ff, o_blk_ff};

   `DMC_ASSERT_IMP(a_stall_only_when_full, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without a blocked result")
   `DMC_ASSERT_IMP(a_word_only_on_hit, rsp_tvalid && (rsp_tuser != dmc_pkg::RSP_HIT), o_word_ff == '0, "nonzero word on a result that is not a hit")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

localparam int NUM_LINES   = 4;
localparam int LINE_WORDS  = 4;
localparam int QUIET_LIMIT = 2000;
localparam int HOLDOFF_LEN = 48;

// One reply word as the block should return it
typedef struct packed {
   logic [2:0]  status;
   logic [3:0]  miss_block;
   logic [31:0] hit_word;
   logic [15:0] hits;
   logic [15:0] misses;
} cache_reply_type;

// Line store mirror: tags, line states, data words and the two counters
class cache_line_model;
   logic [1:0]   line_tag   [NUM_LINES];
   logic [1:0]   line_state [NUM_LINES];
   logic [31:0]  line_words [NUM_LINES*LINE_WORDS];
   logic [15:0]  hit_total;
   logic [15:0]  miss_total;
   cache_reply_type expected_replies[$];
   int unsigned  failures;

   function new();
      foreach (line_tag[i]) begin
         line_tag[i]   = '0;
         line_state[i] = dmc_pkg::LINE_INVALID;
      end
      foreach (line_words[i]) line_words[i] = '0;
      hit_total  = '0;
      miss_total = '0;
      failures   = 0;
   endfunction

   // Apply one accepted request and queue the reply it must produce
   function void note_request(logic func, logic [dmc_pkg::REQ_DATA_W-1:0] data);
      cache_reply_type reply;
      logic [1:0]   idx;
      logic [1:0]   tag;
      logic [1:0]   word_sel;
      reply = '0;
      if (func == dmc_pkg::FUNC_ACCESS) begin
         word_sel = data[3:2];
         idx      = data[5:4];
         tag      = data[7:6];
         if (line_tag[idx] == tag && line_state[idx] == dmc_pkg::LINE_VALID) begin
            reply.status   = dmc_pkg::RSP_HIT;
            reply.hit_word = line_words[{idx, word_sel}];
            if (hit_total != dmc_pkg::CNT_MAX) hit_total = hit_total + 1'b1;
         end else if (line_tag[idx] == tag && line_state[idx] == dmc_pkg::LINE_PENDING) begin
            reply.status = dmc_pkg::RSP_WAIT;
         end else begin
            // miss: claim the line for the new tag and ask for the block
            reply.status     = dmc_pkg::RSP_MISS;
            reply.miss_block = data[7:4];
            line_state[idx]  = dmc_pkg::LINE_PENDING;
            line_tag[idx]    = tag;
            if (miss_total != dmc_pkg::CNT_MAX) miss_total = miss_total + 1'b1;
         end
      end else begin
         idx = data[9:8];
         tag = data[13:12];
         if (tag == line_tag[idx] && line_state[idx] == dmc_pkg::LINE_PENDING) begin
            line_state[idx] = dmc_pkg::LINE_VALID;
            for (int w = 0; w < LINE_WORDS; w++)
               line_words[idx*LINE_WORDS + w] = data[14 + 32*w +: 32];
            reply.status = dmc_pkg::RSP_FILL_OK;
         end else begin
            reply.status = dmc_pkg::RSP_FILL_IGN;
         end
      end
      reply.hits   = hit_total;
      reply.misses = miss_total;
      expected_replies.push_back(reply);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   // Compare one accepted reply word against the oldest expectation
   function void check_reply(logic [dmc_pkg::RSP_DATA_W-1:0] data, logic [2:0] user);
      cache_reply_type want;
      if (expected_replies.size() == 0) begin
         $display("%0t: unexpected reply, expected none, actual status %0h data %0h",
                  $time, user, data);
         failures++;
         return;
      end
      want = expected_replies.pop_front();
      compare_field("status",      want.status,     user);
      compare_field("miss_block",  want.miss_block, data[3:0]);
      compare_field("hit_word",    want.hit_word,   data[35:4]);
      compare_field("hits_seen",   want.hits,       data[51:36]);
      compare_field("misses_seen", want.misses,     data[67:52]);
   endfunction
endclass

module testbench;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dmc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = dmc_pkg::FUNC_ACCESS;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dmc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]                     rsp_tuser;

   cache_line_model model = new();
   int unsigned     send_idle_pct = 0;
   int unsigned     stall_pct = 0;
   bit              long_holdoff = 1'b0;
   int unsigned     quiet_cycles = 0;

   direct_mapped_cache_controller_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold-off on request
   always begin
      @(negedge clock);
      if (long_holdoff) begin
         for (int n = 0; n < HOLDOFF_LEN; n++) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end
         long_holdoff = 1'b0;
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Check every reply word as it is taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) model.check_reply(rsp_tdata, rsp_tuser);
   end

   // Abort when nothing moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one word, hold it until taken, then note it; entered and left at a falling edge
   task automatic drive_word(input logic func, input logic [dmc_pkg::REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model.note_request(func, data);
      @(negedge clock);
   endtask

   task automatic send_access(input logic [7:0] address);
      drive_word(dmc_pkg::FUNC_ACCESS, {{(dmc_pkg::REQ_DATA_W-8){1'b0}}, address});
   endtask

   task automatic send_fill(input logic [3:0] block, input logic [1:0] tag,
                            input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3);
      drive_word(dmc_pkg::FUNC_FILL, {2'b00, w3, w2, w1, w0, tag, block, 8'h00});
   endtask

   task automatic send_random_fill(input logic [3:0] block, input logic [1:0] tag);
      send_fill(block, tag, $urandom(), $urandom(), $urandom(), $urandom());
   endtask

   // Drop valid and hold until every outstanding reply is back
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (model.expected_replies.size() != 0) @(negedge clock);
   endtask

   // One random word: random accesses, accesses to stored tags, fills for pending lines and random fills
   task automatic random_request();
      int unsigned pick;
      logic [1:0]  idx;
      pick = $urandom_range(99);
      idx  = 2'($urandom());
      if (pick < 25) begin
         send_access(8'($urandom()));
      end else if (pick < 50) begin
         send_access({model.line_tag[idx], idx, 4'($urandom())});
      end else if (pick < 80 && model.line_state[idx] == dmc_pkg::LINE_PENDING) begin
         send_random_fill({model.line_tag[idx], idx}, model.line_tag[idx]);
      end else begin
         send_random_fill(4'($urandom()), 2'($urandom()));
      end
   endtask

   initial begin
      int unsigned send_pcts  [4] = '{0, 84, 0, 31};
      int unsigned stall_pcts [4] = '{0, 0, 84, 31};

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: tag match on an invalid line misses, then wait on the pending line
      send_access(8'h00);
      send_access(8'h04);
      send_fill(4'h0, 2'd1, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
      // fill matched by tag only, upper block bits differ
      send_fill(4'h4, 2'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_fill(4'h0, 2'd0, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
      send_access(8'h00);
      send_access(8'h04);
      send_access(8'h08);
      send_access(8'h0C);
      send_access(8'hFF);
      send_access(8'hF3);
      send_fill(4'hF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(8'hFC);
      send_access(8'hF0);
      // evict a valid line, then come back for the old block
      send_access(8'hC0);
      send_access(8'h00);
      send_fill(4'hC, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0);
      send_fill(4'h0, 2'd0, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
      send_access(8'h0B);
      // fill to a line that was never requested is ignored
      send_fill(4'h1, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_access(8'h30);
      send_access(8'h3C);

      // Random phases under different idle patterns
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         stall_pct     = stall_pcts[p];
         for (int i = 0; i < 360; i++) begin
            if (p == 0 && i == 100) long_holdoff = 1'b1;
            if (p == 0 && i == 200) drain_replies();
            random_request();
         end
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      drain_replies();
      repeat (10) @(posedge clock);
      if (model.failures == 0 && model.expected_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
